### rtl/core/ulb_pkg.sv
`timescale 1ns / 1ps

package ulb_pkg;

    // Default picture geometry
    localparam int VIEW_W_DEF    = 320;
    localparam int VIEW_H_DEF    = 200;
    localparam int MAX_SCALE_DEF = 12;

    // Field widths
    localparam int WIN_W     = 12;
    localparam int IDX_W     = 16;
    localparam int COLOR_W   = 32;
    localparam int SCALE_W   = 4;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [WIN_W-1:0]   WIDTH_RESET  = 12'd640;
    localparam logic [WIN_W-1:0]   HEIGHT_RESET = 12'd400;
    localparam logic [COLOR_W-1:0] BG_RESET     = 32'd0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_WIDTH  = 2'd0,
        REG_WINDOW_HEIGHT = 2'd1,
        REG_BACKGROUND    = 2'd2
    } t_cfg_reg;

    // Fit derivation sequencer
    typedef enum logic [1:0] {
        FIT_IDLE,
        FIT_SCALE,
        FIT_PLACE
    } t_fit_state;

    // Placement of the picture in the window
    typedef struct packed {
        logic               busy;
        logic [SCALE_W-1:0] scale;
        logic [WIN_W-1:0]   left;
        logic [WIN_W-1:0]   top;
        logic [WIN_W-1:0]   xlim;
        logic [WIN_W-1:0]   ylim;
        logic [WIN_W-1:0]   wlast;
        logic [WIN_W-1:0]   hlast;
    } t_fit;

    // Raster position flags for the current window pixel
    typedef struct packed {
        logic in_pic;
        logic lend;
        logic fend;
    } t_pos;

endpackage

### rtl/core/ulb_if.sv
`timescale 1ns / 1ps

// Input item channel
interface ulb_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [ulb_pkg::IDX_W-1:0]   view_index;
    logic [ulb_pkg::COLOR_W-1:0] pixel_color;

    modport source (output valid, output op, output view_index, output pixel_color,
                    input ready);
    modport sink   (input valid, input op, input view_index, input pixel_color,
                    output ready);
endinterface

// Result item channel
interface ulb_out_if;
    logic                        valid;
    logic                        ready;
    logic [ulb_pkg::COLOR_W-1:0] out_color;
    logic                        line_end;
    logic                        frame_end;

    modport source (output valid, output out_color, output line_end, output frame_end,
                    input ready);
    modport sink   (input valid, input out_color, input line_end, input frame_end,
                    output ready);
endinterface

// Configuration write channel
interface ulb_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ulb_pkg::CFG_IDX_W-1:0] index;
    logic [ulb_pkg::COLOR_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/ulb_store.sv
`timescale 1ns / 1ps

module ulb_store #(
    parameter int DEPTH  = ulb_pkg::VIEW_W_DEF * ulb_pkg::VIEW_H_DEF,
    parameter int ADDR_W = 16
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [ulb_pkg::COLOR_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [ulb_pkg::COLOR_W-1:0] o_rdata
);

    logic [ulb_pkg::COLOR_W-1:0] mem [DEPTH];
    logic [ulb_pkg::COLOR_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while idle
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/ulb_fit.sv
`timescale 1ns / 1ps

module ulb_fit #(
    parameter int VIEW_W    = ulb_pkg::VIEW_W_DEF,
    parameter int VIEW_H    = ulb_pkg::VIEW_H_DEF,
    parameter int MAX_SCALE = ulb_pkg::MAX_SCALE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ulb_cfg_if.sink                     i_cfg,
    output ulb_pkg::t_fit               o_fit,
    output logic [ulb_pkg::COLOR_W-1:0] o_bg,
    output logic                        o_restart
);

    localparam int WW       = ulb_pkg::WIN_W;
    localparam int SW       = ulb_pkg::SCALE_W;
    localparam int BIG      = (VIEW_W > VIEW_H) ? VIEW_W : VIEW_H;
    localparam int PROD_RAW = $clog2(BIG * MAX_SCALE + 1);
    localparam int PW       = ((PROD_RAW > WW) ? PROD_RAW : WW) + 1;

    logic [WW-1:0]               r_width;
    logic [WW-1:0]               r_height;
    logic [ulb_pkg::COLOR_W-1:0] r_bg;
    ulb_pkg::t_fit_state         r_state;
    ulb_pkg::t_fit_state         n_state;

    logic [SW-1:0] r_scale, n_scale;
    logic [WW-1:0] r_left, n_left, r_top, n_top;
    logic [WW-1:0] r_xlim, n_xlim, r_ylim, n_ylim;
    logic [WW-1:0] r_wlast, r_hlast;

    logic          cfg_wr;
    logic [WW-1:0] w_eff, h_eff;
    logic [PW-1:0] vw, vh;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign o_restart   = cfg_wr && ((i_cfg.index == ulb_pkg::REG_WINDOW_WIDTH) ||
                                    (i_cfg.index == ulb_pkg::REG_WINDOW_HEIGHT));

    // A zero size counts as one pixel
    assign w_eff = (r_width == '0) ? WW'(1) : r_width;
    assign h_eff = (r_height == '0) ? WW'(1) : r_height;

    // Registers and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ulb_pkg::WIDTH_RESET;
            r_height <= ulb_pkg::HEIGHT_RESET;
            r_bg     <= ulb_pkg::BG_RESET;
            r_state  <= ulb_pkg::FIT_SCALE;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (i_cfg.index)
                    ulb_pkg::REG_WINDOW_WIDTH:  r_width  <= i_cfg.data[WW-1:0];
                    ulb_pkg::REG_WINDOW_HEIGHT: r_height <= i_cfg.data[WW-1:0];
                    ulb_pkg::REG_BACKGROUND:    r_bg     <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // Next state: scale first, then offsets and limits
    always_comb begin
        case (r_state)
            ulb_pkg::FIT_SCALE: n_state = ulb_pkg::FIT_PLACE;
            ulb_pkg::FIT_PLACE: n_state = ulb_pkg::FIT_IDLE;
            default:            n_state = ulb_pkg::FIT_IDLE;
        endcase
        if (o_restart) begin
            n_state = ulb_pkg::FIT_SCALE;
        end
    end

    // Largest whole scale that fits both directions
    always_comb begin
        n_scale = SW'(1);
        for (int k = 2; k <= MAX_SCALE; k++) begin
            if ((PW'(w_eff) >= PW'(VIEW_W * k)) && (PW'(h_eff) >= PW'(VIEW_H * k))) begin
                n_scale = SW'(k);
            end
        end
    end

    // Centered offsets and drawn extents
    assign vw = PW'(VIEW_W) * PW'(r_scale);
    assign vh = PW'(VIEW_H) * PW'(r_scale);

    always_comb begin
        n_left = (PW'(w_eff) > vw) ? WW'((PW'(w_eff) - vw) >> 1) : '0;
        n_top  = (PW'(h_eff) > vh) ? WW'((PW'(h_eff) - vh) >> 1) : '0;
        n_xlim = (vw < PW'(w_eff)) ? WW'(vw) : w_eff;
        n_ylim = (vh < PW'(h_eff)) ? WW'(vh) : h_eff;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ulb_pkg::FIT_SCALE) begin
            r_scale <= n_scale;
        end
        if (r_state == ulb_pkg::FIT_PLACE) begin
            r_left  <= n_left;
            r_top   <= n_top;
            r_xlim  <= n_xlim;
            r_ylim  <= n_ylim;
            r_wlast <= w_eff - WW'(1);
            r_hlast <= h_eff - WW'(1);
        end
    end

    always_comb begin
        o_fit.busy  = (r_state != ulb_pkg::FIT_IDLE);
        o_fit.scale = r_scale;
        o_fit.left  = r_left;
        o_fit.top   = r_top;
        o_fit.xlim  = r_xlim;
        o_fit.ylim  = r_ylim;
        o_fit.wlast = r_wlast;
        o_fit.hlast = r_hlast;
    end

    assign o_bg = r_bg;

endmodule

### rtl/core/ulb_raster.sv
`timescale 1ns / 1ps

module ulb_raster #(
    parameter int VIEW_W = ulb_pkg::VIEW_W_DEF,
    parameter int VIEW_H = ulb_pkg::VIEW_H_DEF,
    parameter int ADDR_W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ulb_pkg::t_fit       i_fit,
    input  logic                i_restart,
    input  logic                i_step,
    output ulb_pkg::t_pos       o_pos,
    output logic [ADDR_W-1:0]   o_addr
);

    localparam int WW  = ulb_pkg::WIN_W;
    localparam int SW  = ulb_pkg::SCALE_W;
    localparam int VXW = $clog2(VIEW_W + 1);
    localparam int VYW = $clog2(VIEW_H + 1);

    logic [WW-1:0]  r_col, n_col, r_row, n_row;
    logic [VXW-1:0] r_vx, n_vx;
    logic [VYW-1:0] r_vy, n_vy;
    logic [SW-1:0]  r_xph, n_xph, r_yph, n_yph;
    logic [SW-1:0]  smax;
    logic           h_in, v_in, lend, fend;

    // Position inside the drawn picture
    assign h_in = (r_col >= i_fit.left) && ((r_col - i_fit.left) < i_fit.xlim);
    assign v_in = (r_row >= i_fit.top) && ((r_row - i_fit.top) < i_fit.ylim);
    assign lend = (r_col >= i_fit.wlast);
    assign fend = lend && (r_row >= i_fit.hlast);
    assign smax = i_fit.scale - SW'(1);

    assign o_pos.in_pic = h_in && v_in;
    assign o_pos.lend   = lend;
    assign o_pos.fend   = fend;
    assign o_addr       = ADDR_W'(r_vy) * ADDR_W'(VIEW_W) + ADDR_W'(r_vx);

    // Raster advance with block phase counters standing in for the divide
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_vx  = r_vx;
        n_vy  = r_vy;
        n_xph = r_xph;
        n_yph = r_yph;
        if (lend) begin
            n_col = '0;
            n_vx  = '0;
            n_xph = '0;
            if (fend) begin
                n_row = '0;
                n_vy  = '0;
                n_yph = '0;
            end else begin
                n_row = r_row + WW'(1);
                if (r_row >= i_fit.top) begin
                    if (r_yph == smax) begin
                        n_yph = '0;
                        n_vy  = r_vy + VYW'(1);
                    end else begin
                        n_yph = r_yph + SW'(1);
                    end
                end
            end
        end else begin
            n_col = r_col + WW'(1);
            if (r_col >= i_fit.left) begin
                if (r_xph == smax) begin
                    n_xph = '0;
                    n_vx  = r_vx + VXW'(1);
                end else begin
                    n_xph = r_xph + SW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
            r_vx  <= '0;
            r_vy  <= '0;
            r_xph <= '0;
            r_yph <= '0;
        end else if (i_step) begin
            r_col <= n_col;
            r_row <= n_row;
            r_vx  <= n_vx;
            r_vy  <= n_vy;
            r_xph <= n_xph;
            r_yph <= n_yph;
        end
    end

endmodule

### rtl/core/integer_upscaler_letterbox_top.sv
`timescale 1ns / 1ps

// Integer nearest-neighbor upscaler with letterbox.
// i_in carries items: op 0 writes pixel_color into the view store at view_index
// (addresses past the store are dropped), op 1 asks for the next window pixel
// in raster order. Each op 1 item yields one item on o_out with the color
// (view pixel or background) and line/frame end flags; op 0 yields nothing.
// i_cfg writes window width (0), window height (1) and background color (2).
// A width or height write restarts the raster at the top left corner.
// Results pass a result stage and the output register. One item is taken
// every cycle while o_out is ready, set by the single-port-per-side frame
// store and a one-pass pixel path. After reset (size 640x400) and each width
// or height write, i_in.ready stays low while scale and offsets are derived.
// The view store is not cleared: reading a pixel never written is undefined.
// When o_out stalls, a result stage and the output register hold two items,
// and i_in.ready drops once both are full; nothing is lost.

module integer_upscaler_letterbox_top #(
    parameter int VIEW_W    = ulb_pkg::VIEW_W_DEF,
    parameter int VIEW_H    = ulb_pkg::VIEW_H_DEF,
    parameter int MAX_SCALE = ulb_pkg::MAX_SCALE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ulb_in_if.sink     i_in,
    ulb_out_if.source  o_out,
    ulb_cfg_if.sink    i_cfg
);

    localparam int DEPTH  = VIEW_W * VIEW_H;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = ulb_pkg::COLOR_W;

    ulb_pkg::t_fit     fit;
    ulb_pkg::t_pos     pos;
    logic [CW-1:0]     bg;
    logic              restart;
    logic [ADDR_W-1:0] raddr;
    logic [CW-1:0]     rdata;

    logic accept, emit, wr, s1_adv, out_load;

    logic r_s1_valid, r_s1_inside, r_s1_lend, r_s1_fend;
    logic r_out_valid;
    logic [CW-1:0] r_out_color;
    logic r_out_lend, r_out_fend;

    // Configuration and placement
    ulb_fit #(
        .VIEW_W    (VIEW_W),
        .VIEW_H    (VIEW_H),
        .MAX_SCALE (MAX_SCALE)
    ) u_fit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_fit     (fit),
        .o_bg      (bg),
        .o_restart (restart)
    );

    // Window raster counters
    ulb_raster #(
        .VIEW_W (VIEW_W),
        .VIEW_H (VIEW_H),
        .ADDR_W (ADDR_W)
    ) u_raster (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fit     (fit),
        .i_restart (restart),
        .i_step    (emit),
        .o_pos     (pos),
        .o_addr    (raddr)
    );

    // View frame store
    ulb_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr),
        .i_waddr (ADDR_W'(i_in.view_index)),
        .i_wdata (i_in.pixel_color),
        .i_re    (emit && pos.in_pic),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Handshake and pipeline control
    assign out_load   = !r_out_valid || o_out.ready;
    assign s1_adv     = r_s1_valid && out_load;
    assign i_in.ready = !fit.busy && (!r_s1_valid || s1_adv);
    assign accept     = i_in.valid && i_in.ready;
    assign emit       = accept && i_in.op;
    assign wr         = accept && !i_in.op && (32'(i_in.view_index) < 32'(DEPTH));

    // Result stage: waits for the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (emit) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s1_inside <= pos.in_pic;
            r_s1_lend   <= pos.lend;
            r_s1_fend   <= pos.fend;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_color <= r_s1_inside ? rdata : bg;
            r_out_lend  <= r_s1_lend;
            r_out_fend  <= r_s1_fend;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_color = r_out_color;
    assign o_out.line_end  = r_out_lend;
    assign o_out.frame_end = r_out_fend;

    // Checks
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fit.busy |-> !i_in.ready)
        else $error("item taken while placement is being derived");

    a_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart |=> fit.busy)
        else $error("window size write did not start placement");

    a_frame_on_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.frame_end |-> o_out.line_end)
        else $error("frame end without line end");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_out_valid |=> r_out_valid)
        else $error("result stage did not move into empty output register");

endmodule

### tb/letterbox_pixel_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and register channels of the upscaler, keeps its
// own copy of the view store, window size and raster position, and compares
// every result item against the window pixel it expects.
module letterbox_pixel_checker #(
    parameter logic OP_STORE = 1'b0,
    parameter logic OP_EMIT  = 1'b1
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ulb_in_if    i_in,
    ulb_out_if   i_out,
    ulb_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_next_read
);

    localparam int unsigned VIEW_W      = ulb_pkg::VIEW_W_DEF;
    localparam int unsigned VIEW_H      = ulb_pkg::VIEW_H_DEF;
    localparam int unsigned MAX_SCALE   = ulb_pkg::MAX_SCALE_DEF;
    localparam int unsigned STORE_DEPTH = VIEW_W * VIEW_H;
    localparam int          CW          = ulb_pkg::COLOR_W;
    localparam int          WW          = ulb_pkg::WIN_W;
    localparam int          SW          = ulb_pkg::SCALE_W;

    typedef struct packed {
        logic [CW-1:0] color;
        logic          line_end;
        logic          frame_end;
    } t_window_px;

    logic [CW-1:0] view_mem [0:STORE_DEPTH-1];
    bit            view_set [0:STORE_DEPTH-1];
    t_window_px    window_px_q [$];

    logic [WW-1:0] win_w;
    logic [WW-1:0] win_h;
    logic [CW-1:0] bg_color;
    logic [WW-1:0] ras_col;
    logic [WW-1:0] ras_row;
    logic [SW-1:0] blk_scale;
    logic [WW-1:0] pad_left;
    logic [WW-1:0] pad_top;

    // Largest whole scale that fits, then centered offsets clamped at 0
    function automatic void refit();
        int unsigned w;
        int unsigned h;
        int unsigned s;
        w = (win_w == '0) ? 1 : win_w;
        h = (win_h == '0) ? 1 : win_h;
        s = (w / VIEW_W < h / VIEW_H) ? w / VIEW_W : h / VIEW_H;
        if (s < 1) s = 1;
        if (s > MAX_SCALE) s = MAX_SCALE;
        blk_scale = SW'(s);
        pad_left  = (w > VIEW_W * s) ? WW'((w - VIEW_W * s) / 2) : '0;
        pad_top   = (h > VIEW_H * s) ? WW'((h - VIEW_H * s) / 2) : '0;
    endfunction

    // View address under the raster position, -1 on background
    function automatic int pic_addr();
        int unsigned w;
        int unsigned s;
        int unsigned c;
        int unsigned r;
        int unsigned vis;
        w = (win_w == '0) ? 1 : win_w;
        s = blk_scale;
        c = ras_col;
        r = ras_row;
        // only whole blocks that fit the window width are drawn
        vis = (w - pad_left) / s;
        if (vis > VIEW_W) vis = VIEW_W;
        if (r >= pad_top && r - pad_top < VIEW_H * s &&
            c >= pad_left && c - pad_left < vis * s)
            return int'(((r - pad_top) / s) * VIEW_W + (c - pad_left) / s);
        return -1;
    endfunction

    // Address the next emit would read while it is still unwritten, else -1
    function automatic int next_gap();
        int a;
        a = pic_addr();
        if (a >= 0 && unsigned'(a) < STORE_DEPTH && !view_set[a])
            return a;
        return -1;
    endfunction

    // Color and flags of the pixel at the raster position, then advance it
    function automatic t_window_px next_window_pixel();
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int          addr;
        t_window_px  px;
        w = (win_w == '0) ? 1 : win_w;
        h = (win_h == '0) ? 1 : win_h;
        c = ras_col;
        r = ras_row;
        addr = pic_addr();
        px.color = bg_color;
        if (addr >= 0)
            px.color = (unsigned'(addr) < STORE_DEPTH) ? view_mem[addr] : '0;
        px.line_end  = (c >= w - 1);
        px.frame_end = px.line_end && (r >= h - 1);
        if (px.line_end) begin
            ras_col = '0;
            ras_row = px.frame_end ? '0 : WW'(r + 1);
        end else begin
            ras_col = WW'(c + 1);
        end
        return px;
    endfunction

    always @(posedge i_clk) begin
        t_window_px want;
        t_window_px got;
        if (!i_rst_n) begin
            win_w    = ulb_pkg::WIDTH_RESET;
            win_h    = ulb_pkg::HEIGHT_RESET;
            bg_color = ulb_pkg::BG_RESET;
            ras_col  = '0;
            ras_row  = '0;
            refit();
            window_px_q.delete();
            o_fail_count = 0;
        end else begin
            // results first, so an item accepted on this edge is never matched here
            if (i_out.valid && i_out.ready) begin
                got.color     = i_out.out_color;
                got.line_end  = i_out.line_end;
                got.frame_end = i_out.frame_end;
                if (window_px_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result with nothing pending: color %h lend %b fend %b",
                                 $realtime, got.color, got.line_end, got.frame_end);
                end else begin
                    want = window_px_q.pop_front();
                    if (got.color !== want.color || got.line_end !== want.line_end ||
                        got.frame_end !== want.frame_end) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: pixel mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     $realtime, want.color, want.line_end, want.frame_end,
                                     got.color, got.line_end, got.frame_end);
                    end
                end
            end

            // register writes; width or height restarts the raster
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    ulb_pkg::REG_WINDOW_WIDTH: begin
                        win_w   = i_cfg.data[WW-1:0];
                        ras_col = '0;
                        ras_row = '0;
                        refit();
                    end
                    ulb_pkg::REG_WINDOW_HEIGHT: begin
                        win_h   = i_cfg.data[WW-1:0];
                        ras_col = '0;
                        ras_row = '0;
                        refit();
                    end
                    ulb_pkg::REG_BACKGROUND: bg_color = i_cfg.data;
                    default: ;
                endcase
            end

            // input items: store a view pixel or predict the next window pixel
            if (i_in.valid && i_in.ready) begin
                if (i_in.op == OP_EMIT) begin
                    window_px_q.push_back(next_window_pixel());
                end else if (i_in.op == OP_STORE && i_in.view_index < STORE_DEPTH) begin
                    view_mem[i_in.view_index] = i_in.pixel_color;
                    view_set[i_in.view_index] = 1'b1;
                end
            end
        end
        o_pending   = window_px_q.size();
        o_next_read = next_gap();
    end

endmodule

### tb/integer_upscaler_letterbox_top_tb.sv
`timescale 1ns / 1ps

module integer_upscaler_letterbox_top_tb;

    localparam int   IDX_W        = ulb_pkg::IDX_W;
    localparam int   CW           = ulb_pkg::COLOR_W;
    localparam int   CFG_IDX_W    = ulb_pkg::CFG_IDX_W;
    localparam logic OP_STORE     = 1'b0;
    localparam logic OP_EMIT      = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int   STORE_DEPTH  = ulb_pkg::VIEW_W_DEF * ulb_pkg::VIEW_H_DEF;
    localparam int   RANDOM_ITEMS = 1100;

    logic clk;
    logic rst_n;
    bit   calm;
    bit   calm_done;
    bit   hold_req;
    int   hold_left;
    int   fail_count;
    int   pending;
    int   next_read;
    int   rand_items;

    ulb_in_if  in_ch();
    ulb_out_if out_ch();
    ulb_cfg_if cfg_ch();

    integer_upscaler_letterbox_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    letterbox_pixel_checker #(
        .OP_STORE (OP_STORE),
        .OP_EMIT  (OP_EMIT)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_next_read  (next_read)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Safety net against a hung handshake
    initial begin
        #10ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 23);
    endfunction

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !idle_now();
            end
        end
    end

    // Offer one item at a falling edge and hold it until taken
    task automatic push_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [CW-1:0] color);
        while (idle_now()) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.view_index  <= idx;
        in_ch.pixel_color <= color;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Store the view pixel the next emit reads if it was never written, then emit
    task automatic emit_px();
        while (next_read >= 0)
            push_item(OP_STORE, IDX_W'(next_read), $urandom);
        push_item(OP_EMIT, IDX_W'($urandom), $urandom);
    endtask

    // Wait for all pending pixels, then let the pipeline run dry
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_window(input int w, input int h);
        if ($urandom_range(0, 1)) begin
            write_reg(ulb_pkg::REG_WINDOW_WIDTH, {20'($urandom), 12'(w)});
            write_reg(ulb_pkg::REG_WINDOW_HEIGHT, {20'($urandom), 12'(h)});
        end else begin
            write_reg(ulb_pkg::REG_WINDOW_HEIGHT, {20'($urandom), 12'(h)});
            write_reg(ulb_pkg::REG_WINDOW_WIDTH, {20'($urandom), 12'(w)});
        end
    endtask

    // One random window setting followed by a mix of stores and emits
    task automatic run_phase(input int n_items);
        int w;
        int h;
        int k;
        int sel;
        logic [IDX_W-1:0] idx;
        case ($urandom_range(0, 5))
            0, 5: begin
                // tiny windows reach line and frame ends often
                w = $urandom_range(0, 24);
                h = $urandom_range(0, 12);
            end
            1: begin
                w = $urandom_range(1, 319);
                h = $urandom_range(1, 199);
            end
            2: begin
                // just around the whole-scale steps
                w = 320 * $urandom_range(1, 12) + $urandom_range(0, 6) - 3;
                h = 200 * $urandom_range(1, 20) + $urandom_range(0, 6) - 3;
            end
            3: begin
                w = $urandom_range(0, 4095);
                h = $urandom_range(0, 4095);
            end
            default: begin
                sel = $urandom_range(0, 2);
                w = (sel == 0) ? 0 : (sel == 1) ? 1 : 4095;
                sel = $urandom_range(0, 2);
                h = (sel == 0) ? 0 : (sel == 1) ? 1 : 4095;
            end
        endcase
        set_window(w, h);
        if ($urandom_range(0, 1)) write_reg(ulb_pkg::REG_BACKGROUND, $urandom);
        if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, $urandom);

        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 3) != 0) begin
                emit_px();
            end else begin
                sel = $urandom_range(0, 9);
                if (sel < 6) idx = IDX_W'($urandom_range(0, 4095));
                else if (sel < 9) idx = IDX_W'($urandom_range(0, STORE_DEPTH - 1));
                else idx = IDX_W'($urandom_range(STORE_DEPTH, 65535));
                push_item(OP_STORE, idx, $urandom);
            end
        end
        rand_items += n_items;
    endtask

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.op          = OP_STORE;
        in_ch.view_index  = '0;
        in_ch.pixel_color = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = ulb_pkg::REG_WINDOW_WIDTH;
        cfg_ch.data       = '0;
        calm              = 1'b0;
        calm_done         = 1'b0;
        hold_req          = 1'b0;
        hold_left         = 0;
        rand_items        = 0;
        rst_n             = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: store extremes, dropped addresses, reset-size window
        push_item(OP_STORE, '0, '1);
        push_item(OP_STORE, IDX_W'(STORE_DEPTH - 1), '0);
        push_item(OP_STORE, IDX_W'(STORE_DEPTH), 32'hA5A5_A5A5);
        push_item(OP_STORE, '1, 32'h5A5A_5A5A);
        repeat (4) emit_px();

        // Directed: zero size means 1x1, every pixel ends the frame
        set_window(0, 0);
        repeat (3) emit_px();

        // Directed: largest window saturates the scale, all background at the top
        set_window(4095, 4095);
        write_reg(ulb_pkg::REG_BACKGROUND, '1);
        repeat (3) emit_px();
        write_reg(REG_SPARE, '1);
        repeat (2) emit_px();

        // Directed: narrow window cuts the picture, background write keeps raster
        set_window(5, 3);
        repeat (4) emit_px();
        write_reg(ulb_pkg::REG_BACKGROUND, 32'h0F0F_0F0F);
        repeat (4) emit_px();

        // Back-pressure: results held off while emits keep coming
        set_window(7, 4);
        hold_req = 1'b1;
        repeat (40) emit_px();

        // Random phases, one of them without any idling
        while (rand_items < RANDOM_ITEMS) begin
            if (!calm_done && rand_items >= 300) begin
                calm = 1'b1;
                run_phase(300);
                calm      = 1'b0;
                calm_done = 1'b1;
            end else begin
                run_phase($urandom_range(20, 150));
            end
        end

        settle();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
